FILE: src/owlog_pkg.sv
package owlog_pkg;

  localparam int unsigned CAPACITY = 1024;

  // operation codes
  localparam logic [2:0] OP_WRITE    = 3'd0;
  localparam logic [2:0] OP_LOOKUP   = 3'd1;
  localparam logic [2:0] OP_QSTART   = 3'd2;
  localparam logic [2:0] OP_QNEXT    = 3'd3;
  localparam logic [2:0] OP_READ_POS = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_TIME_LO = 3'd0;
  localparam logic [2:0] CFG_TIME_HI = 3'd1;
  localparam logic [2:0] CFG_SEV_LO  = 3'd2;
  localparam logic [2:0] CFG_SEV_HI  = 3'd3;
  localparam logic [2:0] CFG_LIMIT   = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] entry_id;
    logic [63:0] entry_time;
    logic [7:0]  entry_severity;
    logic [63:0] entry_payload;
    logic [9:0]  position;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [63:0] out_id;
    logic [63:0] out_time;
    logic [7:0]  out_severity;
    logic [63:0] out_payload;
    logic [10:0] stored_count;
    logic [63:0] oldest_id;
    logic [63:0] newest_id;
    logic [63:0] written_total;
    logic [10:0] matches_so_far;
  } out_item_t;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] tstamp;
    logic [7:0]  sev;
    logic [63:0] payload;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_POS_TAKE,
    S_TAIL_RD,
    S_TAIL_TAKE,
    S_FIN
  } state_e;

  typedef struct packed {
    logic cap_item;
    logic do_write;
    logic q_clear;
    logic scan_init;
    logic scan_issue;
    logic scan_hit;
    logic scan_miss;
    logic pos_issue;
    logic entry_take;
    logic tail_issue;
    logic oldest_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pend;
    logic       hit;
    logic       more;
    logic       reached;
    logic       pos_ok;
  } stat_t;

endpackage

FILE: src/overwrite_log_ring_with_lookup_top.sv
// Log ring of CAPACITY entries with lookup, positional read and filtered query.
// Input channel: in_valid_i / in_stall_o carry one in_item_t per operation.
// Output channel: out_valid_o / out_stall_i return exactly one out_item_t per
// operation, in order. Query bounds and result limit are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only while the block
// is idle, which the block does not enforce. Items are handled one at a time;
// in_stall_o is low only while idle. A write steps through dispatch, tail read
// and tail take to its result; a positional read takes its entry after
// dispatch, and an ended query goes from dispatch to its result. Lookup and
// query scan N slots, N at most CAPACITY, one slot a cycle through the single
// read port of the entry store, which sets the worst case per item.
// Reset empties the ring and clears counts, query state and bounds at once;
// no clearing pass is needed, as written slots follow from the fill count.
// A finished result sits in an output register; a new item may be accepted
// while it waits, and the following result is held until out_stall_i drops.
module overwrite_log_ring_with_lookup_top #(
  parameter int unsigned CAPACITY = owlog_pkg::CAPACITY
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  owlog_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output owlog_pkg::out_item_t out_item_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [63:0]          cfg_data_i
);

  owlog_pkg::cmd_t  cmd;
  owlog_pkg::stat_t stat;

  owlog_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  owlog_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

FILE: src/owlog_ram.sv
module owlog_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/owlog_dp.sv
module owlog_dp #(
  parameter int unsigned CAPACITY = owlog_pkg::CAPACITY
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  owlog_pkg::in_item_t  in_item_i,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [63:0]          cfg_data_i,
  input  owlog_pkg::cmd_t      cmd_i,
  output owlog_pkg::stat_t     stat_o,
  output owlog_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = ((CW > 10) ? CW : 10) + 1;
  localparam int unsigned EW = $bits(owlog_pkg::entry_t);

  logic [63:0] tlo_q, thi_q;
  logic [7:0]  slo_q, shi_q;
  logic [10:0] lim_q;

  owlog_pkg::in_item_t  item_q;
  owlog_pkg::entry_t    wentry, rentry;
  owlog_pkg::out_item_t out_q, out_d;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, raddr;
  logic [CW-1:0] count_q, count_d, qcur_q, qcur_d, qmat_q, qmat_d;
  logic [CW-1:0] iss_q, iss_d, tag_q, tag_d;
  logic [63:0]   total_q, total_d, newest_q, newest_d, oldest_q, oldest_d;
  logic          pend_q;
  logic          res_status_q, res_status_d;
  owlog_pkg::entry_t res_q, res_d;
  logic          is_lookup, full, hit_id, hit_filter;

  // ring slot of an offset from a base slot
  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [SW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + off;
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlo_q <= '0;
      thi_q <= '0;
      slo_q <= '0;
      shi_q <= '0;
      lim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        owlog_pkg::CFG_TIME_LO: tlo_q <= cfg_data_i;
        owlog_pkg::CFG_TIME_HI: thi_q <= cfg_data_i;
        owlog_pkg::CFG_SEV_LO:  slo_q <= cfg_data_i[7:0];
        owlog_pkg::CFG_SEV_HI:  shi_q <= cfg_data_i[7:0];
        owlog_pkg::CFG_LIMIT:   lim_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // entry store
  assign wentry.id      = item_q.entry_id;
  assign wentry.tstamp  = item_q.entry_time;
  assign wentry.sev     = item_q.entry_severity;
  assign wentry.payload = item_q.entry_payload;

  owlog_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_write),
    .waddr_i (head_q),
    .wdata_i (wentry),
    .raddr_i (raddr),
    .rdata_o (rentry)
  );

  assign is_lookup = (item_q.op == owlog_pkg::OP_LOOKUP);
  assign full      = (count_q == CW'(CAPACITY));

  // read address select
  always_comb begin
    raddr = tail_q;
    if (cmd_i.scan_issue) begin
      raddr = is_lookup ? iss_q[AW-1:0] : slot_of(tail_q, SW'(iss_q));
    end else if (cmd_i.pos_issue) begin
      raddr = slot_of(tail_q, SW'(item_q.position));
    end else if (cmd_i.tail_issue) begin
      raddr = tail_q;
    end
  end

  // match tests on the read data
  assign hit_id = (rentry.id == item_q.entry_id);
  always_comb begin
    hit_filter = 1'b1;
    if (tlo_q != '0 && rentry.tstamp < tlo_q) hit_filter = 1'b0;
    if (thi_q != '0 && rentry.tstamp > thi_q) hit_filter = 1'b0;
    if (slo_q != '0 && rentry.sev < slo_q) hit_filter = 1'b0;
    if (shi_q != '0 && rentry.sev > shi_q) hit_filter = 1'b0;
  end

  assign stat_o.op      = item_q.op;
  assign stat_o.pend    = pend_q;
  assign stat_o.hit     = is_lookup ? hit_id : hit_filter;
  assign stat_o.more    = (iss_q < count_q);
  assign stat_o.reached = (item_q.op == owlog_pkg::OP_QNEXT) && (lim_q != '0)
                          && (32'(qmat_q) >= 32'(lim_q));
  assign stat_o.pos_ok  = (32'(item_q.position) < 32'(count_q));

  // ring bookkeeping and scan state
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    total_d      = total_q;
    newest_d     = newest_q;
    oldest_d     = oldest_q;
    qcur_d       = qcur_q;
    qmat_d       = qmat_q;
    iss_d        = iss_q;
    tag_d        = tag_q;
    res_status_d = res_status_q;
    res_d        = res_q;
    if (cmd_i.cap_item) begin
      res_status_d = 1'b1;
      res_d        = '0;
    end
    if (cmd_i.do_write) begin
      head_d       = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
      total_d      = total_q + 64'd1;
      newest_d     = item_q.entry_id;
      res_status_d = 1'b0;
      if (full) begin
        tail_d = (tail_q == AW'(CAPACITY - 1)) ? '0 : tail_q + 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
    if (cmd_i.q_clear) begin
      qcur_d = '0;
      qmat_d = '0;
    end
    if (cmd_i.scan_init) begin
      iss_d = (item_q.op == owlog_pkg::OP_QNEXT) ? qcur_q : '0;
    end
    if (cmd_i.scan_issue) begin
      iss_d = iss_q + 1'b1;
      tag_d = iss_q;
    end
    if (cmd_i.scan_hit && !is_lookup) begin
      qcur_d = tag_q + 1'b1;
      qmat_d = qmat_q + 1'b1;
    end
    if (cmd_i.scan_miss && !is_lookup) begin
      qcur_d = iss_q;
    end
    if (cmd_i.entry_take || cmd_i.scan_hit) begin
      res_status_d = 1'b0;
      res_d        = rentry;
    end
    if (cmd_i.oldest_take) begin
      oldest_d = rentry.id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      total_q  <= '0;
      newest_q <= '0;
      oldest_q <= '0;
      qcur_q   <= '0;
      qmat_q   <= '0;
      iss_q    <= '0;
      tag_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      total_q  <= total_d;
      newest_q <= newest_d;
      oldest_q <= oldest_d;
      qcur_q   <= qcur_d;
      qmat_q   <= qmat_d;
      iss_q    <= iss_d;
      tag_q    <= tag_d;
      pend_q   <= cmd_i.scan_issue;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      item_q <= in_item_i;
    end
    res_status_q <= res_status_d;
    res_q        <= res_d;
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d.status         = res_status_q;
    out_d.out_id         = res_q.id;
    out_d.out_time       = res_q.tstamp;
    out_d.out_severity   = res_q.sev;
    out_d.out_payload    = res_q.payload;
    out_d.stored_count   = 11'(count_q);
    out_d.oldest_id      = oldest_q;
    out_d.newest_id      = newest_q;
    out_d.written_total  = total_q;
    out_d.matches_so_far = 11'(qmat_q);
  end

  assign out_item_o = out_q;

  // ring invariants
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("held count above capacity");
  a_head_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (head_q == count_q[AW-1:0] && tail_q == '0))
    else $error("head or tail out of step with fill count");
  a_pend_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (tag_q + 1'b1 == iss_q))
    else $error("scan tag out of step with issue counter");

endmodule

FILE: src/owlog_ctrl.sv
module owlog_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  owlog_pkg::stat_t stat_i,
  output owlog_pkg::cmd_t  cmd_o
);

  owlog_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d, out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      owlog_pkg::S_IDLE: begin
        if (in_valid_i) state_d = owlog_pkg::S_DISPATCH;
      end
      owlog_pkg::S_DISPATCH: begin
        case (stat_i.op)
          owlog_pkg::OP_WRITE:    state_d = owlog_pkg::S_TAIL_RD;
          owlog_pkg::OP_LOOKUP:   state_d = owlog_pkg::S_SCAN;
          owlog_pkg::OP_QSTART:   state_d = owlog_pkg::S_SCAN;
          owlog_pkg::OP_QNEXT:    state_d = stat_i.reached ? owlog_pkg::S_FIN
                                                           : owlog_pkg::S_SCAN;
          owlog_pkg::OP_READ_POS: state_d = stat_i.pos_ok ? owlog_pkg::S_POS_TAKE
                                                          : owlog_pkg::S_FIN;
          default:                state_d = owlog_pkg::S_FIN;
        endcase
      end
      owlog_pkg::S_SCAN: begin
        if (stat_i.pend && stat_i.hit) state_d = owlog_pkg::S_FIN;
        else if (!stat_i.more && !stat_i.pend) state_d = owlog_pkg::S_FIN;
      end
      owlog_pkg::S_POS_TAKE:  state_d = owlog_pkg::S_FIN;
      owlog_pkg::S_TAIL_RD:   state_d = owlog_pkg::S_TAIL_TAKE;
      owlog_pkg::S_TAIL_TAKE: state_d = owlog_pkg::S_FIN;
      owlog_pkg::S_FIN: begin
        if (out_free) state_d = owlog_pkg::S_IDLE;
      end
      default: state_d = owlog_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      owlog_pkg::S_IDLE: cmd_o.cap_item = in_valid_i;
      owlog_pkg::S_DISPATCH: begin
        case (stat_i.op)
          owlog_pkg::OP_WRITE: cmd_o.do_write = 1'b1;
          owlog_pkg::OP_LOOKUP: cmd_o.scan_init = 1'b1;
          owlog_pkg::OP_QSTART: begin
            cmd_o.q_clear   = 1'b1;
            cmd_o.scan_init = 1'b1;
          end
          owlog_pkg::OP_QNEXT: cmd_o.scan_init = !stat_i.reached;
          owlog_pkg::OP_READ_POS: cmd_o.pos_issue = stat_i.pos_ok;
          default: ;
        endcase
      end
      owlog_pkg::S_SCAN: begin
        if (stat_i.pend && stat_i.hit) cmd_o.scan_hit = 1'b1;
        else if (stat_i.more) cmd_o.scan_issue = 1'b1;
        else if (!stat_i.pend) cmd_o.scan_miss = 1'b1;
      end
      owlog_pkg::S_POS_TAKE:  cmd_o.entry_take = 1'b1;
      owlog_pkg::S_TAIL_RD:   cmd_o.tail_issue = 1'b1;
      owlog_pkg::S_TAIL_TAKE: cmd_o.oldest_take = 1'b1;
      owlog_pkg::S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= owlog_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != owlog_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  // sequencing checks
  a_fin_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == owlog_pkg::S_FIN && out_valid_q && out_stall_i) |=>
      state_q == owlog_pkg::S_FIN)
    else $error("result overwrote a stalled item");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("loaded result not shown");
  a_one_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.scan_hit, cmd_o.scan_issue, cmd_o.scan_miss}))
    else $error("conflicting scan commands");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RING = owlog_pkg::CAPACITY;
  localparam int unsigned STALL_LIMIT = 20000;

  // ring predictor and store of expected results
  class ring_scoreboard;
    bit [63:0] id_mem [RING];
    bit [63:0] time_mem [RING];
    bit [7:0]  sev_mem [RING];
    bit [63:0] pay_mem [RING];
    bit        filled [RING];
    int unsigned head, tail, held;
    bit [63:0] total;
    int unsigned cursor, hits;
    bit [63:0] t_lo, t_hi;
    bit [7:0]  s_lo, s_hi;
    bit [10:0] limit;
    owlog_pkg::out_item_t pending_q[$];
    int unsigned errors;

    function new();
      for (int i = 0; i < RING; i++) filled[i] = 0;
      head = 0; tail = 0; held = 0; total = 0; cursor = 0; hits = 0;
      t_lo = 0; t_hi = 0; s_lo = 0; s_hi = 0; limit = 0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        owlog_pkg::CFG_TIME_LO: t_lo = val;
        owlog_pkg::CFG_TIME_HI: t_hi = val;
        owlog_pkg::CFG_SEV_LO:  s_lo = val[7:0];
        owlog_pkg::CFG_SEV_HI:  s_hi = val[7:0];
        owlog_pkg::CFG_LIMIT:   limit = val[10:0];
        default: ;
      endcase
    endfunction

    function void fill_entry(ref owlog_pkg::out_item_t r, input int unsigned slot);
      r.status = 1'b0;
      r.out_id = id_mem[slot];
      r.out_time = time_mem[slot];
      r.out_severity = sev_mem[slot];
      r.out_payload = pay_mem[slot];
    endfunction

    function bit keeps(int unsigned slot);
      if (t_lo != 0 && time_mem[slot] < t_lo) return 0;
      if (t_hi != 0 && time_mem[slot] > t_hi) return 0;
      if (s_lo != 0 && sev_mem[slot] < s_lo) return 0;
      if (s_hi != 0 && sev_mem[slot] > s_hi) return 0;
      return 1;
    endfunction

    // next match of the running query, oldest first
    function void scan_query(ref owlog_pkg::out_item_t r);
      int unsigned slot;
      if (limit != 0 && hits >= limit) return;
      while (cursor < held) begin
        slot = (tail + cursor) % RING;
        cursor++;
        if (keeps(slot)) begin
          hits++;
          fill_entry(r, slot);
          return;
        end
      end
    endfunction

    function void note_input(owlog_pkg::in_item_t it);
      owlog_pkg::out_item_t r;
      r = '0;
      r.status = 1'b1;
      case (it.op)
        owlog_pkg::OP_WRITE: begin
          id_mem[head] = it.entry_id;
          time_mem[head] = it.entry_time;
          sev_mem[head] = it.entry_severity;
          pay_mem[head] = it.entry_payload;
          filled[head] = 1;
          head = (head + 1) % RING;
          total++;
          if (held < RING) held++;
          else tail = (tail + 1) % RING;
          r.status = 1'b0;
        end
        owlog_pkg::OP_LOOKUP: begin
          for (int i = 0; i < RING; i++) begin
            if (filled[i] && id_mem[i] == it.entry_id) begin
              fill_entry(r, i);
              break;
            end
          end
        end
        owlog_pkg::OP_QSTART: begin
          cursor = 0;
          hits = 0;
          scan_query(r);
        end
        owlog_pkg::OP_QNEXT: scan_query(r);
        owlog_pkg::OP_READ_POS: begin
          if (it.position < held) fill_entry(r, (tail + it.position) % RING);
        end
        default: ;
      endcase
      r.stored_count = held[10:0];
      r.oldest_id = held > 0 ? id_mem[tail] : '0;
      r.newest_id = held > 0 ? id_mem[(head + RING - 1) % RING] : '0;
      r.written_total = total;
      r.matches_so_far = hits[10:0];
      pending_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: mismatch %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check(owlog_pkg::out_item_t got);
      owlog_pkg::out_item_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none actual %h", $time, got);
        return;
      end
      want = pending_q.pop_front();
      cmp_field("status", 64'(want.status), 64'(got.status));
      cmp_field("out_id", want.out_id, got.out_id);
      cmp_field("out_time", want.out_time, got.out_time);
      cmp_field("out_severity", 64'(want.out_severity), 64'(got.out_severity));
      cmp_field("out_payload", want.out_payload, got.out_payload);
      cmp_field("stored_count", 64'(want.stored_count), 64'(got.stored_count));
      cmp_field("oldest_id", want.oldest_id, got.oldest_id);
      cmp_field("newest_id", want.newest_id, got.newest_id);
      cmp_field("written_total", want.written_total, got.written_total);
      cmp_field("matches_so_far", 64'(want.matches_so_far), 64'(got.matches_so_far));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  owlog_pkg::in_item_t  in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  owlog_pkg::out_item_t out_item_o;
  logic                 cfg_we_i = 1'b0;
  logic [2:0]           cfg_idx_i = '0;
  logic [63:0]          cfg_data_i = '0;

  ring_scoreboard sb = new();
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          stall_mode = 0;

  overwrite_log_ring_with_lookup_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side: check and watch for a hang
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check(out_item_o);
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver stall: runs of free and stalled cycles, a few long ones
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = ($urandom_range(0, 2) == 0);
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 4);
    end
    stall_left--;
    out_stall_i <= stall_mode;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_item(owlog_pkg::in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // block idle: input low, every result back, then a margin
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_bounds(logic [63:0] tlo, logic [63:0] thi, logic [7:0] slo,
                            logic [7:0] shi, logic [10:0] lim);
    settle();
    write_reg(owlog_pkg::CFG_TIME_LO, tlo);
    write_reg(owlog_pkg::CFG_TIME_HI, thi);
    write_reg(owlog_pkg::CFG_SEV_LO, {56'd0, slo});
    write_reg(owlog_pkg::CFG_SEV_HI, {56'd0, shi});
    write_reg(owlog_pkg::CFG_LIMIT, {53'd0, lim});
  endtask

  function automatic owlog_pkg::in_item_t mk(logic [2:0] op, logic [63:0] id,
                                             logic [63:0] tm, logic [7:0] sev,
                                             logic [9:0] pos);
    owlog_pkg::in_item_t it;
    it.op = op;
    it.entry_id = id;
    it.entry_time = tm;
    it.entry_severity = sev;
    it.entry_payload = {$urandom, $urandom};
    it.position = pos;
    return it;
  endfunction

  function automatic owlog_pkg::in_item_t rand_item(logic [2:0] op);
    logic [63:0] id, tm;
    logic [9:0] pos;
    id = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 31)) : {$urandom, $urandom};
    tm = ($urandom_range(0, 3) != 0) ? 64'($urandom_range(0, 1000)) : {$urandom, $urandom};
    pos = ($urandom_range(0, 1) == 0 || sb.held == 0) ? 10'($urandom)
                                                      : 10'($urandom_range(0, sb.held - 1));
    return mk(op, id, tm, 8'($urandom), pos);
  endfunction

  // bursts of writes, query runs and single operations
  task automatic random_phase(int unsigned n);
    int unsigned sent, k, sel;
    logic [2:0] op;
    sent = 0;
    while (sent < n) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        k = $urandom_range(1, 20);
        repeat (k) send_item(rand_item(owlog_pkg::OP_WRITE));
        sent += k;
      end else if (sel < 6) begin
        k = $urandom_range(1, 8);
        send_item(rand_item(owlog_pkg::OP_QSTART));
        repeat (k) send_item(rand_item(owlog_pkg::OP_QNEXT));
        sent += k + 1;
      end else begin
        sel = $urandom_range(0, 19);
        op = (sel < 8) ? owlog_pkg::OP_LOOKUP : (sel < 15) ? owlog_pkg::OP_READ_POS
           : (sel < 17) ? owlog_pkg::OP_QNEXT : 3'($urandom_range(5, 7));
        send_item(rand_item(op));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty ring: every read misses
    send_item(mk(owlog_pkg::OP_LOOKUP, 64'd0, 64'd0, 8'd0, 10'd0));
    send_item(mk(owlog_pkg::OP_READ_POS, 64'd0, 64'd0, 8'd0, 10'd0));
    send_item(mk(owlog_pkg::OP_QSTART, 64'd0, 64'd0, 8'd0, 10'd0));
    // extremes of the fields
    send_item(mk(owlog_pkg::OP_WRITE, 64'd0, 64'd0, 8'd0, 10'd0));
    send_item(mk(owlog_pkg::OP_WRITE, '1, '1, 8'hff, '1));
    send_item(mk(owlog_pkg::OP_WRITE, 64'd5, 64'd300, 8'd100, 10'd0));
    send_item(mk(owlog_pkg::OP_WRITE, 64'd5, 64'd400, 8'd120, 10'd0));
    send_item(mk(owlog_pkg::OP_LOOKUP, '1, 64'd0, 8'd0, 10'd0));
    send_item(mk(owlog_pkg::OP_LOOKUP, 64'd5, 64'd0, 8'd0, 10'd0));
    send_item(mk(owlog_pkg::OP_LOOKUP, 64'd0, 64'd0, 8'd0, 10'd0));
    send_item(mk(owlog_pkg::OP_LOOKUP, 64'd77, 64'd0, 8'd0, 10'd0));
    send_item(mk(owlog_pkg::OP_READ_POS, 64'd0, 64'd0, 8'd0, 10'd3));
    send_item(mk(owlog_pkg::OP_READ_POS, 64'd0, 64'd0, 8'd0, 10'd4));
    send_item(mk(owlog_pkg::OP_READ_POS, 64'd0, 64'd0, 8'd0, 10'd1023));
    send_item(mk(owlog_pkg::OP_QSTART, 64'd0, 64'd0, 8'd0, 10'd0));
    repeat (4) send_item(mk(owlog_pkg::OP_QNEXT, 64'd0, 64'd0, 8'd0, 10'd0));
    // unknown operations leave the ring unchanged and still return one result
    send_item(mk(3'd5, '1, '1, 8'hff, '1));
    send_item(mk(3'd6, 64'd5, 64'd0, 8'd0, 10'd0));
    send_item(mk(3'd7, 64'd0, 64'd0, 8'd0, 10'd0));

    set_bounds(64'd100, 64'd800, 8'd50, 8'd200, 11'd5);
    random_phase(120);
    random_phase(80);
    set_bounds('1, '1, 8'hff, 8'hff, 11'd1024);
    random_phase(60);
    set_bounds(64'd1, '1, 8'd1, 8'd255, 11'd1);
    random_phase(80);
    set_bounds(64'd500, 64'd0, 8'd0, 8'd128, 11'd0);
    random_phase(80);
    set_bounds(64'd0, 64'd300, 8'd200, 8'd0, 11'd3);
    random_phase(80);
    set_bounds(64'd0, 64'd0, 8'd0, 8'd0, 11'd0);
    random_phase(80);

    settle();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
